/* hdl/rfc3339_timestamp_parser_assert.svh */
// Assertion macros shared by the timestamp parser checkers.
`ifndef RFC3339_TIMESTAMP_PARSER_ASSERT_SVH
`define RFC3339_TIMESTAMP_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rtp_pkg.sv */
// Shared types, constants and tables of the timestamp parser.
`timescale 1ns / 1ps
package rtp_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_FIELD = 2'd1,
    ERR_FRAC  = 2'd2,
    ERR_ZONE  = 2'd3
  } err_t;

  // One parsed timestamp handed from the parser to the converter.
  typedef struct packed {
    err_t        err;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        zneg;
    logic [4:0]  zhours;
    logic [5:0]  zminutes;
  } rec_t;

  // Days before the first of a month, months counted from March.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] v;
    unique case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/rtp_fifo.sv */
// Short record queue between the character parser and the converter.
`timescale 1ns / 1ps
module rtp_fifo #(
  parameter int DEPTH = rtp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rtp_pkg::rec_t push_rec,
  output logic          full,
  input  logic          pop,
  output rtp_pkg::rec_t head_rec,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtp_pkg::rec_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

/* hdl/rtp_front.sv */
// Character parser: checks layout and ranges, builds one record per timestamp.
`timescale 1ns / 1ps
module rtp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    text_char,
  input  logic          last_char,
  output logic          rec_push,
  output rtp_pkg::rec_t rec
);

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [4:0] DATE_LEN = 5'd19;

  typedef enum logic [1:0] {
    PH_DATE = 2'd0,
    PH_DOT  = 2'd1,
    PH_FRAC = 2'd2,
    PH_ZONE = 2'd3
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [4:0]        idx_r, idx_nxt;
  logic [13:0]       year_r, year_nxt;
  logic [3:0]        month_r, month_nxt;
  logic [4:0]        day_r, day_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        minute_r, minute_nxt;
  logic [5:0]        second_r, second_nxt;
  logic              zneg_r, zneg_nxt;
  logic [4:0]        zh_r, zh_nxt;
  logic [5:0]        zm_r, zm_nxt;
  rtp_pkg::err_t     ferr_r, ferr_nxt;
  logic [1:0]        hmod4_r, hmod4_nxt;
  logic [3:0]        y1_r, y1_nxt;
  logic              leap_r, leap_nxt;

  rtp_pkg::err_t     serr;
  logic              isd;
  logic [3:0]        dig;
  logic              zone_go;
  logic [2:0]        zp;
  logic [7:0]        r2;
  logic [6:0]        lo;

  // Second digit of a two-digit field: {ok, value}, value zero when bad.
  function automatic logic [7:0] chk2(input logic [6:0] first, input logic [3:0] d,
                                      input logic ok_digit, input logic [6:0] lo_lim,
                                      input logic [6:0] hi_lim);
    logic [6:0] v;
    v = 7'(first * 7'd10) + 7'(d);
    return (ok_digit && v >= lo_lim && v <= hi_lim) ? {1'b1, v} : 8'd0;
  endfunction

  function automatic logic [6:0] month_len(input logic [3:0] m, input logic leap);
    logic [6:0] n;
    unique case (m)
      4'd2:                      n = leap ? 7'd29 : 7'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 7'd30;
      default:                   n = 7'd31;
    endcase
    return n;
  endfunction

  assign isd = (text_char >= CH_D0) && (text_char <= CH_D9);
  assign dig = isd ? text_char[3:0] : 4'd0;

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    zneg_nxt   = zneg_r;
    zh_nxt     = zh_r;
    zm_nxt     = zm_r;
    hmod4_nxt  = hmod4_r;
    y1_nxt     = y1_r;
    leap_nxt   = leap_r;
    serr       = rtp_pkg::ERR_NONE;
    zone_go    = 1'b0;
    zp         = 3'd0;
    r2         = 8'd0;
    lo         = 7'd0;

    unique case (phase_r)
      PH_DATE: begin
        if (idx_r < DATE_LEN) begin
          unique case (idx_r)
            5'd0, 5'd1, 5'd2, 5'd3: begin
              year_nxt = 14'(year_r * 14'd10) + 14'(dig);
              if (!isd) serr = rtp_pkg::ERR_FIELD;
              if (idx_r == 5'd2) begin
                // year_r holds the century pair here
                hmod4_nxt = year_r[1:0];
                y1_nxt    = dig;
              end
              if (idx_r == 5'd3) begin
                lo       = 7'(y1_r * 7'd10) + 7'(dig);
                leap_nxt = ((lo[1:0] == 2'd0) && (lo != 7'd0)) ||
                           ((lo == 7'd0) && (hmod4_r == 2'd0));
              end
            end
            5'd4, 5'd7: if (text_char != CH_DASH) serr = rtp_pkg::ERR_FIELD;
            5'd10:      if (text_char != CH_T) serr = rtp_pkg::ERR_FIELD;
            5'd13, 5'd16: if (text_char != CH_COLON) serr = rtp_pkg::ERR_FIELD;
            5'd5: begin
              month_nxt = dig;
              if (!isd) serr = rtp_pkg::ERR_FIELD;
            end
            5'd6: begin
              r2 = chk2(7'(month_r), dig, isd, 7'd1, 7'd12);
              month_nxt = r2[3:0];
              if (!r2[7]) serr = rtp_pkg::ERR_FIELD;
            end
            5'd8: begin
              day_nxt = 5'(dig);
              if (!isd) serr = rtp_pkg::ERR_FIELD;
            end
            5'd9: begin
              r2 = chk2(7'(day_r), dig, isd, 7'd1, month_len(month_r, leap_r));
              day_nxt = r2[4:0];
              if (!r2[7]) serr = rtp_pkg::ERR_FIELD;
            end
            5'd11: begin
              hour_nxt = 5'(dig);
              if (!isd) serr = rtp_pkg::ERR_FIELD;
            end
            5'd12: begin
              r2 = chk2(7'(hour_r), dig, isd, 7'd0, 7'd23);
              hour_nxt = r2[4:0];
              if (!r2[7]) serr = rtp_pkg::ERR_FIELD;
            end
            5'd14: begin
              minute_nxt = 6'(dig);
              if (!isd) serr = rtp_pkg::ERR_FIELD;
            end
            5'd15: begin
              r2 = chk2(7'(minute_r), dig, isd, 7'd0, 7'd59);
              minute_nxt = r2[5:0];
              if (!r2[7]) serr = rtp_pkg::ERR_FIELD;
            end
            5'd17: begin
              second_nxt = 6'(dig);
              if (!isd) serr = rtp_pkg::ERR_FIELD;
            end
            5'd18: begin
              r2 = chk2(7'(second_r), dig, isd, 7'd0, 7'd59);
              second_nxt = r2[5:0];
              if (!r2[7]) serr = rtp_pkg::ERR_FIELD;
            end
            default: ;
          endcase
          idx_nxt = idx_r + 5'd1;
          if (last_char) serr = rtp_pkg::ERR_FIELD;
        end else if (text_char == CH_DOT) begin
          phase_nxt = PH_DOT;
          if (last_char) serr = rtp_pkg::ERR_FRAC;
        end else begin
          zone_go = 1'b1;
        end
      end
      PH_DOT: begin
        if (isd) begin
          phase_nxt = PH_FRAC;
          if (last_char) serr = rtp_pkg::ERR_ZONE;
        end else begin
          serr    = rtp_pkg::ERR_FRAC;
          zone_go = 1'b1;
        end
      end
      PH_FRAC: begin
        if (isd) begin
          if (last_char) serr = rtp_pkg::ERR_ZONE;
        end else begin
          zone_go = 1'b1;
        end
      end
      PH_ZONE: zone_go = 1'b1;
      default: ;
    endcase

    if (zone_go) begin
      zp        = (phase_r == PH_ZONE) ? idx_r[2:0] : 3'd0;
      phase_nxt = PH_ZONE;
      unique case (zp)
        3'd0: begin
          if (text_char == CH_Z) begin
            if (!last_char && serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
          end else if (text_char == CH_PLUS || text_char == CH_DASH) begin
            zneg_nxt = (text_char == CH_DASH);
          end else if (serr == rtp_pkg::ERR_NONE) begin
            serr = rtp_pkg::ERR_ZONE;
          end
        end
        3'd1: begin
          zh_nxt = 5'(dig);
          if (!isd && serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
        end
        3'd2: begin
          r2 = chk2(7'(zh_r), dig, isd, 7'd0, 7'd23);
          zh_nxt = r2[4:0];
          if (!r2[7] && serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
        end
        3'd3: begin
          if (text_char != CH_COLON && serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
        end
        3'd4: begin
          zm_nxt = 6'(dig);
          if (!isd && serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
        end
        3'd5: begin
          r2 = chk2(7'(zm_r), dig, isd, 7'd0, 7'd59);
          zm_nxt = r2[5:0];
          if (!r2[7] && serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
        end
        default: if (serr == rtp_pkg::ERR_NONE) serr = rtp_pkg::ERR_ZONE;
      endcase
      // zone must end right after 'Z' or after the minutes
      if (last_char && !(zp == 3'd0 && text_char == CH_Z) && zp != 3'd5 &&
          serr == rtp_pkg::ERR_NONE) begin
        serr = rtp_pkg::ERR_ZONE;
      end
      idx_nxt = (zp == 3'd7) ? 5'd7 : 5'(zp) + 5'd1;
    end

    ferr_nxt = (ferr_r != rtp_pkg::ERR_NONE) ? ferr_r : serr;
  end

  assign rec_push     = accept && last_char;
  assign rec.err      = ferr_nxt;
  assign rec.year     = year_nxt;
  assign rec.month    = month_nxt;
  assign rec.day      = day_nxt;
  assign rec.hour     = hour_nxt;
  assign rec.minute   = minute_nxt;
  assign rec.second   = second_nxt;
  assign rec.zneg     = zneg_nxt;
  assign rec.zhours   = zh_nxt;
  assign rec.zminutes = zm_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_char)) begin
      phase_r  <= PH_DATE;
      idx_r    <= '0;
      year_r   <= '0;
      month_r  <= '0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      zneg_r   <= 1'b0;
      zh_r     <= '0;
      zm_r     <= '0;
      ferr_r   <= rtp_pkg::ERR_NONE;
      hmod4_r  <= '0;
      y1_r     <= '0;
      leap_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      year_r   <= year_nxt;
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      zneg_r   <= zneg_nxt;
      zh_r     <= zh_nxt;
      zm_r     <= zm_nxt;
      ferr_r   <= ferr_nxt;
      hmod4_r  <= hmod4_nxt;
      y1_r     <= y1_nxt;
      leap_r   <= leap_nxt;
    end
  end

endmodule

/* hdl/rtp_back.sv */
// Converter: civil date and time of a record to Unix seconds, with output word register.
`timescale 1ns / 1ps
module rtp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rtp_pkg::rec_t       q_head,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [1:0]          out_error_code,
  output logic signed [38:0]  out_unix_seconds
);

  // 719468 days to the epoch plus 146097 for the 400-year bias, plus one for day-1
  localparam logic signed [23:0] DAY_BIAS = 24'sd865566;

  typedef enum logic [2:0] {
    B_IDLE,
    B_PREP,
    B_MUL,
    B_DAYS,
    B_SCALE,
    B_DONE
  } bstate_t;

  bstate_t              state_r;
  logic                 out_valid_r;
  logic [1:0]           out_err_r;
  logic signed [38:0]   out_secs_r;

  rtp_pkg::rec_t        rec_r;
  logic [13:0]          yy_r;
  logic [3:0]           mp_r;
  logic [16:0]          tod_r;
  logic [16:0]          off_r;
  logic [22:0]          prod_r;
  logic [21:0]          y365_r;
  logic signed [18:0]   adj_r;
  logic signed [22:0]   days_r;
  logic signed [38:0]   scaled_r;

  logic [7:0]           c25;
  logic [5:0]           c100;
  logic signed [23:0]   day_sum;
  logic signed [40:0]   day_prod;
  logic signed [38:0]   secs;
  logic                 out_free;

  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign out_free = !out_valid_r || out_pop;

  // floor(q/25) by reciprocal, exact for q below 2600
  assign c25  = prod_r[22:15];
  assign c100 = c25[7:2];
  assign day_sum = $signed({2'b00, y365_r}) + $signed({12'd0, yy_r[13:2]})
                 - $signed({16'd0, c25}) + $signed({18'd0, c100})
                 + $signed({15'd0, rtp_pkg::month_start(mp_r)})
                 + $signed({19'd0, rec_r.day}) - DAY_BIAS;
  assign day_prod = days_r * 18'sd86400;
  assign secs = (rec_r.err != rtp_pkg::ERR_NONE) ? '0 :
                scaled_r + {{20{adj_r[18]}}, adj_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      out_err_r   <= rtp_pkg::ERR_NONE;
      out_secs_r  <= '0;
    end else begin
      if (out_valid_r && out_pop) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE:  if (!q_empty) state_r <= B_PREP;
        B_PREP:  state_r <= B_MUL;
        B_MUL:   state_r <= B_DAYS;
        B_DAYS:  state_r <= B_SCALE;
        B_SCALE: state_r <= B_DONE;
        B_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_err_r   <= rec_r.err;
            out_secs_r  <= secs;
            state_r     <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: if (!q_empty) rec_r <= q_head;
      B_PREP: begin
        // Jan and Feb count with the previous year
        yy_r  <= rec_r.year + 14'd400 - ((rec_r.month <= 4'd2) ? 14'd1 : 14'd0);
        mp_r  <= (rec_r.month >= 4'd3) ? rec_r.month - 4'd3 : rec_r.month + 4'd9;
        tod_r <= 17'(rec_r.hour * 17'd3600) + 17'(rec_r.minute * 17'd60)
               + 17'(rec_r.second);
        off_r <= 17'(rec_r.zhours * 17'd3600) + 17'(rec_r.zminutes * 17'd60);
      end
      B_MUL: begin
        prod_r <= 23'(yy_r[13:2] * 23'd1311);
        y365_r <= 22'(yy_r * 22'd365);
        adj_r  <= rec_r.zneg ? $signed({2'b00, tod_r}) + $signed({2'b00, off_r})
                             : $signed({2'b00, tod_r}) - $signed({2'b00, off_r});
      end
      B_DAYS:  days_r   <= day_sum[22:0];
      B_SCALE: scaled_r <= day_prod[38:0];
      default: ;
    endcase
  end

  assign out_empty        = !out_valid_r;
  assign out_error_code   = out_err_r;
  assign out_unix_seconds = out_secs_r;

endmodule

/* hdl/rfc3339_timestamp_parser.sv */
// Timestamp parser: one character per cycle in while in_full is low, one checked Unix
// time word per timestamp out. A timestamp's record goes from the queue through the
// converter states PREP, MUL, DAYS, SCALE and DONE before out_empty goes low, and waits
// in DONE while an output word is held. The converter takes a new record only from IDLE,
// so records arriving faster, or a held output word, fill the 2-deep queue and raise in_full.
// Reset (synchronous, rst_n low): parser back to the date field, queue and output empty.
`timescale 1ns / 1ps
module rfc3339_timestamp_parser #(
  parameter int QUEUE_DEPTH = rtp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_text_char,
  input  logic               in_last_char,
  input  logic               in_push,
  output logic               in_full,
  output logic [1:0]         out_error_code,
  output logic signed [38:0] out_unix_seconds,
  output logic               out_empty,
  input  logic               out_pop
);

  logic          accept;
  logic          rec_push;
  rtp_pkg::rec_t rec;
  logic          q_full;
  logic          q_empty;
  logic          q_pop;
  rtp_pkg::rec_t q_head;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  rtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .text_char (in_text_char),
    .last_char (in_last_char),
    .rec_push  (rec_push),
    .rec       (rec)
  );

  rtp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec),
    .full     (q_full),
    .pop      (q_pop),
    .head_rec (q_head),
    .empty    (q_empty)
  );

  rtp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_error_code   (out_error_code),
    .out_unix_seconds (out_unix_seconds)
  );

endmodule

/* hdl/rtp_checker.sv */
// Port-level checks of the timestamp parser, bound to the top level.
`timescale 1ns / 1ps
`include "rfc3339_timestamp_parser_assert.svh"
module rtp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic [1:0]         out_error_code,
  input logic signed [38:0] out_unix_seconds,
  input logic               out_empty,
  input logic               out_pop
);

  // a failed timestamp carries no time
  `RTP_ASSERT_NOW(a_err_zero_secs, clk, rst_n, !out_empty && out_error_code != 2'd0, out_unix_seconds == 39'sd0, "error word with nonzero seconds")

  // year 0 to 9999 with any legal zone offset
  `RTP_ASSERT_NOW(a_secs_range, clk, rst_n, !out_empty, out_unix_seconds >= -39'sd62167305540 && out_unix_seconds <= 39'sd253402387139, "seconds outside the civil range")

  // a waiting word is neither dropped nor altered
  `RTP_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_unix_seconds) && $stable(out_error_code), "waiting word changed")

  // first cycle after reset: queue and output start empty
  `RTP_ASSERT_NOW(a_reset_empty, clk, rst_n, !$past(rst_n), out_empty && !in_full, "not empty after reset")

endmodule

bind rfc3339_timestamp_parser rtp_checker u_rtp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_error_code   (out_error_code),
  .out_unix_seconds (out_unix_seconds),
  .out_empty        (out_empty),
  .out_pop          (out_pop)
);
